@@ rtl/gpdq_pkg.sv @@
// Shared types and constants for the gray pixel dither quantiser.
// Used by gpdq_front, gpdq_queue, gpdq_back and the top level.
package gpdq_pkg;

	// position hash multipliers
	localparam logic [31:0] HASH_KX = 32'd374761393;
	localparam logic [31:0] HASH_KY = 32'd668265263;
	localparam logic [31:0] HASH_KM = 32'd1274126177;

	// divide by 100 as multiply by 5243 then shift by 19 (exact for values below 2^15)
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [7:0] THR_LO  = 8'd45;
	localparam logic [7:0] THR_MID = 8'd70;
	localparam logic [7:0] THR_HI  = 8'd140;
	localparam logic [7:0] MID_GRAY = 8'd128;
	localparam logic [7:0] MAX_GRAY = 8'd255;

	// register map
	localparam int          REG_IDX_W     = 3;
	localparam int          PADDR_W       = 5;
	localparam logic [REG_IDX_W-1:0] REG_ADJUST_EN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAMMA_EN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NOISE_EN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BRIGHT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CONTRAST  = 3'd4;
	localparam logic [5:0] BRIGHT_RST   = 6'd10;
	localparam logic [7:0] CONTRAST_RST = 8'd115;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// gamma divider: quotient of (b*255)/v1 with v1 >= 128 fits in 9 bits
	localparam int DIV_STAGES = 9;

	// item classes decided at the front
	typedef logic [2:0] op_t;
	localparam op_t OP_FIX2   = 3'd0;	// 2-bit, fixed thresholds
	localparam op_t OP_NOISE2 = 3'd1;	// 2-bit, hash-noise dither
	localparam op_t OP_BIN    = 3'd2;	// 1-bit, raw gray
	localparam op_t OP_ADJ    = 3'd3;	// 1-bit, contrast and brightness
	localparam op_t OP_ADJG   = 3'd4;	// 1-bit, adjustment plus gamma

	typedef struct packed {
		logic       adjust_en;
		logic       gamma_en;
		logic       noise_en;
		logic [5:0] bright;
		logic [7:0] contrast;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        gray;
		logic [31:0]       hx;
		logic [31:0]       hy;
		logic signed [15:0] cprod;
	} qent_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] gray;
		logic [7:0] t;
		logic [7:0] b;
	} carry_t;

endpackage

@@ rtl/gpdq_front.sv @@
// Front end: takes pixel beats, classifies them and forms the hash and contrast products.
// Depends on gpdq_pkg; feeds gpdq_queue.
module gpdq_front (
	input  logic            clk,
	input  logic            arst_n,
	input  gpdq_pkg::cfg_t  cfg,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  logic            func,
	input  logic [7:0]      gray_level,
	input  logic [15:0]     x_pos,
	input  logic [15:0]     y_pos,
	output logic            q_push,
	output gpdq_pkg::qent_t q_din,
	input  logic            q_full
);
	import gpdq_pkg::*;

	logic               en;
	op_t                op_c;
	logic               vld_s1, vld_s2;
	op_t                op_s1, op_s2;
	logic [7:0]         gray_s1, gray_s2;
	logic [15:0]        x_s1, y_s1;
	logic [31:0]        hx_c, hy_c, hx_s2, hy_s2;
	logic signed [8:0]  dg_c;
	logic signed [17:0] cp_c;
	logic signed [15:0] cprod_s2;

	assign en        = !vld_s2 || !q_full;
	assign pix_ready = en;
	assign q_push    = vld_s2 && !q_full;

	always_comb begin
		if (!func) begin
			op_c = cfg.noise_en ? OP_NOISE2 : OP_FIX2;
		end else if (!cfg.adjust_en) begin
			op_c = OP_BIN;
		end else begin
			op_c = cfg.gamma_en ? OP_ADJG : OP_ADJ;
		end
	end

	assign hx_c = {16'd0, x_s1} * HASH_KX;
	assign hy_c = {16'd0, y_s1} * HASH_KY;
	assign dg_c = $signed({1'b0, gray_s1}) - $signed({1'b0, MID_GRAY});
	assign cp_c = 18'(dg_c) * 18'($signed({1'b0, cfg.contrast}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op_c;
			gray_s1  <= gray_level;
			x_s1     <= x_pos;
			y_s1     <= y_pos;
			op_s2    <= op_s1;
			gray_s2  <= gray_s1;
			hx_s2    <= hx_c;
			hy_s2    <= hy_c;
			cprod_s2 <= cp_c[15:0];
		end
	end

	assign q_din = '{op: op_s2, gray: gray_s2, hx: hx_s2, hy: hy_s2, cprod: cprod_s2};

endmodule

@@ rtl/gpdq_queue.sv @@
// Short FIFO that decouples the front end from the back end.
// Depends on gpdq_pkg for the entry type and depth.
module gpdq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gpdq_pkg::qent_t din,
	output logic            full,
	input  logic            pop,
	output gpdq_pkg::qent_t dout,
	output logic            nempty
);
	import gpdq_pkg::*;

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign dout   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty) else $error("queue popped while empty");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/gpdq_back.sv @@
// Back end: finishes the hash, the adjustment and the gamma divide, then quantises.
// Depends on gpdq_pkg; takes entries from gpdq_queue.
module gpdq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gpdq_pkg::cfg_t  cfg,
	input  logic            q_nempty,
	output logic            q_pop,
	input  gpdq_pkg::qent_t q_dout,
	output logic            lvl_valid,
	input  logic            lvl_ready,
	output logic [1:0]      level
);
	import gpdq_pkg::*;

	function automatic logic [1:0] level_fixed(input logic [7:0] g);
		logic [1:0] r;
		if (g < THR_LO) begin
			r = 2'd0;
		end else if (g < THR_MID) begin
			r = 2'd1;
		end else if (g < THR_HI) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [1:0] level_noise(input logic [7:0] g, input logic [7:0] t);
		logic [10:0] s;
		logic [10:0] band;
		logic [1:0]  r;
		s = 11'({g, 1'b0}) + 11'(g);
		if (s < 11'd255) begin
			band = s;
			r    = 2'd0;
		end else if (s < 11'd510) begin
			band = s - 11'd255;
			r    = 2'd1;
		end else begin
			band = s - 11'd510;
			r    = 2'd2;
		end
		if (band + 11'(t) >= 11'd255) begin
			r = r + 2'd1;
		end
		return r;
	endfunction

	// 128 + (t - 128) / 2 with the halving truncated toward zero
	function automatic logic [7:0] noise_thr(input logic [7:0] t);
		logic [7:0] m;
		logic [7:0] r;
		if (t[7]) begin
			r = 8'd64 + {1'b0, t[7:1]};
		end else begin
			m = MID_GRAY - t;
			r = MID_GRAY - {1'b0, m[7:1]};
		end
		return r;
	endfunction

	logic en;

	// stage 1: hash sum, contrast quotient
	logic               vld_s1;
	op_t                op_s1;
	logic [7:0]         gray_s1;
	logic [31:0]        h_s1;
	logic [8:0]         cq_s1;
	logic               cneg_s1;
	logic               cneg_c;
	logic [14:0]        cmag_c;
	logic [15:0]        cabs_c;
	logic [27:0]        cmul_c;

	// stage 2: noise byte, adjusted gray
	logic               vld_s2;
	op_t                op_s2;
	logic [7:0]         gray_s2, t_s2, b_s2;
	logic [31:0]        hm_c;
	logic signed [10:0] cs_c, c1_c;
	logic [7:0]         c8_c;
	logic [8:0]         bsum_c;
	logic [7:0]         b8_c;

	// stage 3: divider set-up
	logic               vld_s3;
	carry_t             car_s3;
	logic [7:0]         v1_s3;
	logic [15:0]        rem_s3;
	logic [8:0]         v1sum_c;

	// divider pipeline, one quotient bit a stage
	logic                  div_vld_q   [DIV_STAGES];
	carry_t                div_car_q   [DIV_STAGES];
	logic [7:0]            div_v1_q    [DIV_STAGES];
	logic [15:0]           div_rem_q   [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_quo_q   [DIV_STAGES];

	// output register
	logic       out_vld_q;
	logic [1:0] level_q;
	op_t        op_out_q;

	assign en        = !out_vld_q || lvl_ready;
	assign q_pop     = en && q_nempty;
	assign lvl_valid = out_vld_q;
	assign level     = level_q;

	// stage 1
	assign cneg_c = q_dout.cprod[15];
	assign cabs_c = cneg_c ? (16'd0 - q_dout.cprod) : q_dout.cprod;
	assign cmag_c = cabs_c[14:0];
	assign cmul_c = {13'd0, cmag_c} * {15'd0, RECIP_100};

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= q_dout.op;
			gray_s1 <= q_dout.gray;
			h_s1    <= q_dout.hx + q_dout.hy;
			cq_s1   <= cmul_c[27:RECIP_SHIFT];
			cneg_s1 <= cneg_c;
		end
	end

	// stage 2
	assign hm_c   = (h_s1 ^ (h_s1 >> 13)) * HASH_KM;
	assign cs_c   = cneg_s1 ? -$signed({2'b00, cq_s1}) : $signed({2'b00, cq_s1});
	assign c1_c   = cs_c + $signed({3'b000, MID_GRAY});
	assign c8_c   = c1_c[10] ? 8'd0 : ((c1_c > 11'sd255) ? MAX_GRAY : c1_c[7:0]);
	assign bsum_c = {1'b0, c8_c} + {3'b000, cfg.bright};
	assign b8_c   = bsum_c[8] ? MAX_GRAY : bsum_c[7:0];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			gray_s2 <= gray_s1;
			t_s2    <= hm_c[31:24];
			b_s2    <= b8_c;
		end
	end

	// stage 3: the first Newton step from b gives (b + 255) / 2 exactly
	assign v1sum_c = {1'b0, b_s2} + {1'b0, MAX_GRAY};

	always_ff @(posedge clk) begin
		if (en) begin
			car_s3 <= '{op: op_s2, gray: gray_s2, t: t_s2, b: b_s2};
			v1_s3  <= v1sum_c[8:1];
			rem_s3 <= {b_s2, 8'd0} - {8'd0, b_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= q_nempty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - k;
		logic                  vld_in;
		carry_t                car_in;
		logic [7:0]            v1_in;
		logic [15:0]           rem_in;
		logic [DIV_STAGES-1:0] quo_in;
		logic [16:0]           dsh;
		logic                  take;

		if (k == 0) begin : g_first
			assign vld_in = vld_s3;
			assign car_in = car_s3;
			assign v1_in  = v1_s3;
			assign rem_in = rem_s3;
			assign quo_in = '0;
		end else begin : g_next
			assign vld_in = div_vld_q[k-1];
			assign car_in = div_car_q[k-1];
			assign v1_in  = div_v1_q[k-1];
			assign rem_in = div_rem_q[k-1];
			assign quo_in = div_quo_q[k-1];
		end

		assign dsh  = {9'd0, v1_in} << SH;
		assign take = ({1'b0, rem_in} >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_q[k] <= 1'b0;
			end else if (en) begin
				div_vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_car_q[k] <= car_in;
				div_v1_q[k]  <= v1_in;
				div_rem_q[k] <= take ? (rem_in - dsh[15:0]) : rem_in;
				div_quo_q[k] <= quo_in | (DIV_STAGES'(take) << SH);
			end
		end
	end

	// final stage: second Newton step, gamma clamp, threshold compare
	carry_t                car_f;
	logic [DIV_STAGES-1:0] quo_f;
	logic [9:0]            v2sum_c;
	logic [8:0]            v2_c;
	logic [7:0]            gam_c;
	logic [7:0]            g_c;
	logic [1:0]            level_c;

	assign car_f   = div_car_q[DIV_STAGES-1];
	assign quo_f   = div_quo_q[DIV_STAGES-1];
	assign v2sum_c = {2'b00, div_v1_q[DIV_STAGES-1]} + {1'b0, quo_f};
	assign v2_c    = v2sum_c[9:1];
	assign gam_c   = (car_f.b == 8'd0) ? 8'd0 : (v2_c[8] ? MAX_GRAY : v2_c[7:0]);

	always_comb begin
		case (car_f.op)
			OP_ADJ:  g_c = car_f.b;
			OP_ADJG: g_c = gam_c;
			default: g_c = car_f.gray;
		endcase
		case (car_f.op)
			OP_FIX2:   level_c = level_fixed(car_f.gray);
			OP_NOISE2: level_c = level_noise(car_f.gray, car_f.t);
			default:   level_c = {1'b0, (g_c >= noise_thr(car_f.t))};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q  <= level_c;
			op_out_q <= car_f.op;
		end
	end

	a_bin_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_valid && op_out_q != OP_FIX2 && op_out_q != OP_NOISE2) |-> !level[1])
		else $error("1-bit result carries a high bit");
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_q[DIV_STAGES-1] && car_f.op == OP_ADJG && car_f.b != 8'd0)
		|-> (quo_f <= DIV_STAGES'(508)))
		else $error("gamma quotient out of range");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_q[DIV_STAGES-1] |-> (div_rem_q[DIV_STAGES-1] < {8'd0, div_v1_q[DIV_STAGES-1]}))
		else $error("gamma divider remainder not reduced");

endmodule

@@ rtl/gray_pixel_dither_quantizer.sv @@
// Top level of the gray pixel dither quantiser: APB register file and the front/queue/back chain.
// Depends on gpdq_pkg, gpdq_front, gpdq_queue and gpdq_back.
//
// Usage:
//   Pixel channel (pix_valid/pix_ready): one beat carries func, gray_level, x_pos and y_pos.
//   Level channel (lvl_valid/lvl_ready): one beat of level for every pixel beat, in order.
//   APB port: registers at byte offsets 0x00 adjust_enable, 0x04 gamma_enable,
//   0x08 noise_dither_enable, 0x0C brightness_offset, 0x10 contrast_percent.
//   pready is tied high; write registers only while no pixel is in flight.
// Timing:
//   One pixel a clock sustained while lvl_ready stays high. A pixel accepted passes through
//   two front stages, the queue, three back stages, nine divider stages for the gamma
//   square-root step (one quotient bit each) and the output register before its level shows.
// Reset:
//   arst_n clears all valids and the queue; registers return to brightness 10, contrast 115,
//   all enables off.
// Stalls:
//   While lvl_valid is high and lvl_ready low the back end holds; the 4-beat queue keeps
//   taking front-end beats until full, after which pix_ready drops.
module gray_pixel_dither_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gpdq_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic                          func,
	input  logic [7:0]                    gray_level,
	input  logic [15:0]                   x_pos,
	input  logic [15:0]                   y_pos,
	output logic                          lvl_valid,
	input  logic                          lvl_ready,
	output logic [1:0]                    level
);
	import gpdq_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 q_push, q_full, q_pop, q_nempty;
	qent_t                q_din, q_dout;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adjust_en <= 1'b0;
			cfg_q.gamma_en  <= 1'b0;
			cfg_q.noise_en  <= 1'b0;
			cfg_q.bright    <= BRIGHT_RST;
			cfg_q.contrast  <= CONTRAST_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ADJUST_EN: cfg_q.adjust_en <= pwdata[0];
				REG_GAMMA_EN:  cfg_q.gamma_en  <= pwdata[0];
				REG_NOISE_EN:  cfg_q.noise_en  <= pwdata[0];
				REG_BRIGHT:    cfg_q.bright    <= pwdata[5:0];
				REG_CONTRAST:  cfg_q.contrast  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ADJUST_EN: prdata = {31'd0, cfg_q.adjust_en};
			REG_GAMMA_EN:  prdata = {31'd0, cfg_q.gamma_en};
			REG_NOISE_EN:  prdata = {31'd0, cfg_q.noise_en};
			REG_BRIGHT:    prdata = {26'd0, cfg_q.bright};
			REG_CONTRAST:  prdata = {24'd0, cfg_q.contrast};
			default:       prdata = 32'd0;
		endcase
	end

	gpdq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.func       (func),
		.gray_level (gray_level),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.q_push     (q_push),
		.q_din      (q_din),
		.q_full     (q_full)
	);

	gpdq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.nempty (q_nempty)
	);

	gpdq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_nempty  (q_nempty),
		.q_pop     (q_pop),
		.q_dout    (q_dout),
		.lvl_valid (lvl_valid),
		.lvl_ready (lvl_ready),
		.level     (level)
	);

endmodule
